@@ sv/spcr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sphere pair collision resolver: shared types and constants
// Word layouts of both channels, datapath widths and side-band records that
// travel alongside the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package spcr_pkg;

    localparam int CRD_W    = 32;             // centre coordinate, Q16.16
    localparam int RAD_W    = 31;             // radius
    localparam int RSUM_W   = RAD_W + 1;      // radius sum
    localparam int MAG_W    = 32;             // |p1 - p2| per axis
    localparam int SUM_W    = 66;             // |d|^2
    localparam int ROOT_W   = SUM_W / 2;      // distance, one bit per step
    localparam int SQ_REM_W = ROOT_W + 2;     // square-root partial remainder
    localparam int DEP_W    = ROOT_W;         // |depth|
    localparam int DEN_W    = ROOT_W + 1;     // 2 * distance
    localparam int NUM_W    = 66;             // |depth| * |d_i|
    localparam int QUO_W    = 33;             // quotient bits resolved
    localparam int HALF_W   = MAG_W / 2;      // multiplier split
    localparam int PP_W     = DEP_W + HALF_W; // partial product

    typedef struct packed {
        logic signed [CRD_W-1:0] first_x;
        logic signed [CRD_W-1:0] first_y;
        logic signed [CRD_W-1:0] first_z;
        logic        [RAD_W-1:0] first_radius;
        logic                    first_movable;
        logic signed [CRD_W-1:0] second_x;
        logic signed [CRD_W-1:0] second_y;
        logic signed [CRD_W-1:0] second_z;
        logic        [RAD_W-1:0] second_radius;
        logic                    second_movable;
    } pair_t;

    typedef struct packed {
        logic                    overlapping;
        logic signed [CRD_W-1:0] first_dx;
        logic signed [CRD_W-1:0] first_dy;
        logic signed [CRD_W-1:0] first_dz;
        logic signed [CRD_W-1:0] second_dx;
        logic signed [CRD_W-1:0] second_dy;
        logic signed [CRD_W-1:0] second_dz;
        logic                    degenerate;
    } result_t;

    // Carried through the square-root pipeline
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            cneg;
        logic [RSUM_W-1:0]     rsum;
        logic                  mov1;
        logic                  mov2;
    } sq_side_t;

    // Carried through the divider pipeline
    typedef struct packed {
        logic [2:0] cneg;
        logic       dneg;
        logic       overlapping;
        logic       degenerate;
        logic       mov1;
        logic       mov2;
    } div_side_t;

endpackage

@@ sv/sphere_pair_collision_resolve.sv @@
// Throughput: one pair per cycle; busy is always low, the 33-step square-root
//   pipeline and the 33-step divider pipeline each hold one pair per stage.
// Reset: rst_n clears every valid bit at once; no pair is in flight after it.
// The receiver cannot stall: result_valid marks each word for one cycle only.
// ----------------------------------------------------------------------------
// Sphere pair collision resolver
// Overlap test and positional correction of two spheres along their normal,
// signed Q16.16 throughout, saturated displacements.
// ----------------------------------------------------------------------------
module sphere_pair_collision_resolve
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  spcr_pkg::pair_t     pair,
    output logic                result_valid,
    output spcr_pkg::result_t   result
);

    // ------------------------------------------------------------------
    // Stage 1: per-axis differences, split into sign and magnitude
    // ------------------------------------------------------------------
    logic                           s1_vld_reg;
    spcr_pkg::sq_side_t             s1_side_reg;
    spcr_pkg::sq_side_t             s1_side_next;
    logic [2:0][spcr_pkg::CRD_W:0]  diff_next;

    // Stage 2: squares of each magnitude
    logic                                 s2_vld_reg;
    logic [2:0][2*spcr_pkg::MAG_W-1:0]    s2_sq_reg;
    spcr_pkg::sq_side_t                   s2_side_reg;
    logic [spcr_pkg::SUM_W-1:0]           sum_next;

    // Square root
    logic                           sq_vld;
    logic [spcr_pkg::ROOT_W-1:0]    sq_root;
    spcr_pkg::sq_side_t             sq_side;

    // Depth stage
    logic                                 dp_vld_reg;
    logic [spcr_pkg::ROOT_W-1:0]          dp_dist_reg;
    logic [spcr_pkg::DEP_W-1:0]           dp_dmag_reg;
    logic [2:0][spcr_pkg::MAG_W-1:0]      dp_mag_reg;
    spcr_pkg::div_side_t                  dp_side_reg;
    logic [spcr_pkg::DEP_W:0]             depth_next;
    logic [spcr_pkg::DEP_W:0]             depth_abs_next;

    // Divider
    logic                                 dv_vld;
    logic [2:0][spcr_pkg::QUO_W-1:0]      dv_quo;
    logic [2:0][spcr_pkg::DEN_W-1:0]      dv_rem;
    logic [2:0]                           dv_big;
    logic [spcr_pkg::DEN_W-1:0]           dv_den;
    spcr_pkg::div_side_t                  dv_side;

    // Output
    logic                                 out_vld_reg;
    spcr_pkg::result_t                    out_word_reg;
    spcr_pkg::result_t                    out_word_next;

    // Nothing ever holds off a pair
    assign busy = 1'b0;

    // Saturate a sign-magnitude quotient to the signed 32-bit range
    function automatic logic [spcr_pkg::CRD_W-1:0] sat_comp
    (
        input logic                       big,
        input logic [spcr_pkg::QUO_W:0]   mag,
        input logic                       neg
    );
        logic [spcr_pkg::QUO_W:0] lim;
        logic [spcr_pkg::QUO_W:0] val;
        lim = {{(spcr_pkg::QUO_W + 1 - spcr_pkg::CRD_W){1'b0}}, 1'b1,
               {(spcr_pkg::CRD_W - 1){1'b0}}};
        val = mag;
        if (neg)
        begin
            if (big || (val > lim))
            begin
                val = lim;
            end
            val = -val;
        end
        else
        begin
            if (big || (val >= lim))
            begin
                val = lim - 1'b1;
            end
        end
        return val[spcr_pkg::CRD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    always_comb
    begin
        diff_next[0] = {pair.first_x[spcr_pkg::CRD_W-1], pair.first_x}
                     - {pair.second_x[spcr_pkg::CRD_W-1], pair.second_x};
        diff_next[1] = {pair.first_y[spcr_pkg::CRD_W-1], pair.first_y}
                     - {pair.second_y[spcr_pkg::CRD_W-1], pair.second_y};
        diff_next[2] = {pair.first_z[spcr_pkg::CRD_W-1], pair.first_z}
                     - {pair.second_z[spcr_pkg::CRD_W-1], pair.second_z};
        s1_side_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            logic [spcr_pkg::CRD_W:0] neg_d;
            neg_d = -diff_next[i];
            s1_side_next.cneg[i] = diff_next[i][spcr_pkg::CRD_W];
            s1_side_next.mag[i]  = diff_next[i][spcr_pkg::CRD_W]
                                 ? neg_d[spcr_pkg::MAG_W-1:0]
                                 : diff_next[i][spcr_pkg::MAG_W-1:0];
        end
        s1_side_next.rsum = {1'b0, pair.first_radius} + {1'b0, pair.second_radius};
        s1_side_next.mov1 = pair.first_movable;
        s1_side_next.mov2 = pair.second_movable;
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            dp_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start & ~busy;
            s2_vld_reg  <= s1_vld_reg;
            dp_vld_reg  <= sq_vld;
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= s1_side_next;
        s2_side_reg <= s1_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            s2_sq_reg[i] <= s1_side_reg.mag[i] * s1_side_reg.mag[i];
        end
    end

    // Sum of squares feeds the root's load stage
    assign sum_next = {2'b00, s2_sq_reg[0]} + {2'b00, s2_sq_reg[1]}
                    + {2'b00, s2_sq_reg[2]};

    spcr_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .in_sq     (sum_next),
        .in_side   (s2_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ------------------------------------------------------------------
    // Depth stage: penetration depth, overlap and coincidence
    // ------------------------------------------------------------------
    always_comb
    begin
        depth_next     = {{(spcr_pkg::DEP_W + 1 - spcr_pkg::RSUM_W){1'b0}}, sq_side.rsum}
                       - {1'b0, sq_root};
        depth_abs_next = -depth_next;
    end

    always_ff @(posedge clk)
    begin
        dp_dist_reg             <= sq_root;
        dp_dmag_reg             <= depth_next[spcr_pkg::DEP_W]
                                 ? depth_abs_next[spcr_pkg::DEP_W-1:0]
                                 : depth_next[spcr_pkg::DEP_W-1:0];
        dp_mag_reg              <= sq_side.mag;
        dp_side_reg.cneg        <= sq_side.cneg;
        dp_side_reg.dneg        <= depth_next[spcr_pkg::DEP_W];
        dp_side_reg.overlapping <= ({1'b0, sq_root} < {{(spcr_pkg::ROOT_W + 1
                                   - spcr_pkg::RSUM_W){1'b0}}, sq_side.rsum});
        dp_side_reg.degenerate  <= (sq_root == '0);
        dp_side_reg.mov1        <= sq_side.mov1;
        dp_side_reg.mov2        <= sq_side.mov2;
    end

    spcr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dp_vld_reg),
        .in_dist   (dp_dist_reg),
        .in_dmag   (dp_dmag_reg),
        .in_mag    (dp_mag_reg),
        .in_side   (dp_side_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_rem   (dv_rem),
        .out_big   (dv_big),
        .out_den   (dv_den),
        .out_side  (dv_side)
    );

    // ------------------------------------------------------------------
    // Output stage: pick half or full depth, apply sign, saturate, zero if fixed or degenerate.
    // Full depth doubles the quotient and takes one more bit from the
    // remainder, so one divide per axis serves both spheres.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [2:0][spcr_pkg::CRD_W-1:0] f_val;
        logic [2:0][spcr_pkg::CRD_W-1:0] s_val;
        logic [spcr_pkg::QUO_W:0]        half_q;
        logic [spcr_pkg::QUO_W:0]        full_q;
        logic                            extra;
        logic                            full_big;
        logic                            kill1;
        logic                            kill2;

        kill1 = dv_side.degenerate | ~dv_side.mov1;
        kill2 = dv_side.degenerate | ~dv_side.mov2;
        for (int i = 0; i < 3; i++)
        begin
            extra    = ({dv_rem[i], 1'b0} >= {1'b0, dv_den});
            half_q   = {1'b0, dv_quo[i]};
            full_q   = {dv_quo[i], extra};
            full_big = dv_big[i];
            if (dv_side.mov1 && dv_side.mov2)
            begin
                f_val[i] = sat_comp(dv_big[i], half_q, dv_side.dneg ^ dv_side.cneg[i]);
                s_val[i] = sat_comp(dv_big[i], half_q, ~(dv_side.dneg ^ dv_side.cneg[i]));
            end
            else
            begin
                f_val[i] = sat_comp(full_big, full_q, dv_side.dneg ^ dv_side.cneg[i]);
                s_val[i] = sat_comp(full_big, full_q, ~(dv_side.dneg ^ dv_side.cneg[i]));
            end
            if (kill1)
            begin
                f_val[i] = '0;
            end
            if (kill2)
            begin
                s_val[i] = '0;
            end
        end

        out_word_next.overlapping = dv_side.overlapping;
        out_word_next.first_dx    = f_val[0];
        out_word_next.first_dy    = f_val[1];
        out_word_next.first_dz    = f_val[2];
        out_word_next.second_dx   = s_val[0];
        out_word_next.second_dy   = s_val[1];
        out_word_next.second_dz   = s_val[2];
        out_word_next.degenerate  = dv_side.degenerate;
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_word_reg;

endmodule

@@ sv/spcr_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt(x)) of a 66-bit value, one root bit per stage, restoring form.
// ----------------------------------------------------------------------------
module spcr_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [spcr_pkg::SUM_W-1:0]   in_sq,
    input  spcr_pkg::sq_side_t           in_side,
    output logic                         out_valid,
    output logic [spcr_pkg::ROOT_W-1:0]  out_root,
    output spcr_pkg::sq_side_t           out_side
);

    localparam int N = spcr_pkg::ROOT_W;

    logic                            vld_reg  [0:N];
    logic [spcr_pkg::SQ_REM_W-1:0]   rem_reg  [0:N];
    logic [spcr_pkg::ROOT_W-1:0]     root_reg [0:N];
    logic [spcr_pkg::SUM_W-1:0]      rad_reg  [0:N];
    spcr_pkg::sq_side_t              side_reg [0:N];

    // Load stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        rad_reg[0]  <= in_sq;
        side_reg[0] <= in_side;
    end

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic [spcr_pkg::SQ_REM_W+1:0] t_next;
        logic [spcr_pkg::SQ_REM_W+1:0] trial_next;
        logic [spcr_pkg::SQ_REM_W+1:0] diff_next;
        logic                          ge_next;

        always_comb
        begin
            t_next     = {rem_reg[g], rad_reg[g][spcr_pkg::SUM_W-1 -: 2]};
            trial_next = {{(spcr_pkg::SQ_REM_W - spcr_pkg::ROOT_W){1'b0}}, root_reg[g], 2'b01};
            ge_next    = (t_next >= trial_next);
            diff_next  = t_next - trial_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        // Accept the trial bit when the remainder covers it
        always_ff @(posedge clk)
        begin
            rem_reg[g+1]  <= ge_next ? diff_next[spcr_pkg::SQ_REM_W-1:0]
                                     : t_next[spcr_pkg::SQ_REM_W-1:0];
            root_reg[g+1] <= {root_reg[g][spcr_pkg::ROOT_W-2:0], ge_next};
            rad_reg[g+1]  <= {rad_reg[g][spcr_pkg::SUM_W-3:0], 2'b00};
            side_reg[g+1] <= side_reg[g];
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

@@ sv/spcr_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined scaled divider, three lanes
// Forms |depth| * |d_i| and divides it by 2 * dist, one quotient bit per
// stage. Quotients above the resolved range flag big.
// ----------------------------------------------------------------------------
module spcr_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [spcr_pkg::ROOT_W-1:0]          in_dist,
    input  logic [spcr_pkg::DEP_W-1:0]           in_dmag,
    input  logic [2:0][spcr_pkg::MAG_W-1:0]      in_mag,
    input  spcr_pkg::div_side_t                  in_side,
    output logic                                 out_valid,
    output logic [2:0][spcr_pkg::QUO_W-1:0]      out_quo,
    output logic [2:0][spcr_pkg::DEN_W-1:0]      out_rem,
    output logic [2:0]                           out_big,
    output logic [spcr_pkg::DEN_W-1:0]           out_den,
    output spcr_pkg::div_side_t                  out_side
);

    localparam int N = spcr_pkg::QUO_W;

    // Multiply stages
    logic                                    p1_vld_reg;
    logic [spcr_pkg::DEN_W-1:0]              p1_den_reg;
    logic [2:0][spcr_pkg::PP_W-1:0]          p1_lo_reg;
    logic [2:0][spcr_pkg::PP_W-1:0]          p1_hi_reg;
    spcr_pkg::div_side_t                     p1_side_reg;

    logic                                    p2_vld_reg;
    logic [spcr_pkg::DEN_W-1:0]              p2_den_reg;
    logic [2:0][spcr_pkg::NUM_W-1:0]         p2_num_reg;
    spcr_pkg::div_side_t                     p2_side_reg;

    // Long-division stages
    logic                                    vld_reg  [0:N];
    logic [spcr_pkg::DEN_W-1:0]              den_reg  [0:N];
    logic [2:0][spcr_pkg::DEN_W-1:0]         rem_reg  [0:N];
    logic [2:0][spcr_pkg::QUO_W-1:0]         bits_reg [0:N];
    logic [2:0][spcr_pkg::QUO_W-1:0]         quo_reg  [0:N];
    logic [2:0]                              big_reg  [0:N];
    spcr_pkg::div_side_t                     side_reg [0:N];

    logic [2:0]                              big_next;
    logic [spcr_pkg::NUM_W+1:0]              lim_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= in_valid;
            p2_vld_reg <= p1_vld_reg;
            vld_reg[0] <= p2_vld_reg;
        end
    end

    // Split each magnitude into halves to keep the multipliers narrow
    always_ff @(posedge clk)
    begin
        p1_den_reg  <= {in_dist, 1'b0};
        p1_side_reg <= in_side;
        for (int i = 0; i < 3; i++)
        begin
            p1_lo_reg[i] <= in_dmag * in_mag[i][spcr_pkg::HALF_W-1:0];
            p1_hi_reg[i] <= in_dmag * in_mag[i][spcr_pkg::MAG_W-1:spcr_pkg::HALF_W];
        end
    end

    always_ff @(posedge clk)
    begin
        p2_den_reg  <= p1_den_reg;
        p2_side_reg <= p1_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            p2_num_reg[i] <= {{(spcr_pkg::NUM_W - spcr_pkg::PP_W){1'b0}}, p1_lo_reg[i]}
                           + {{(spcr_pkg::NUM_W - spcr_pkg::PP_W - spcr_pkg::HALF_W){1'b0}},
                              p1_hi_reg[i], {spcr_pkg::HALF_W{1'b0}}};
        end
    end

    // Flag quotients of 2^QUO_W or more, then seed the remainder
    always_comb
    begin
        lim_next = {1'b0, p2_den_reg, {N{1'b0}}};
        for (int i = 0; i < 3; i++)
        begin
            big_next[i] = ({2'b00, p2_num_reg[i]} >= lim_next);
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0]  <= p2_den_reg;
        side_reg[0] <= p2_side_reg;
        big_reg[0]  <= big_next;
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[0][i]  <= {1'b0, p2_num_reg[i][spcr_pkg::NUM_W-1:N]};
            bits_reg[0][i] <= p2_num_reg[i][N-1:0];
            quo_reg[0][i]  <= '0;
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic [2:0][spcr_pkg::DEN_W:0] t_next;
        logic [2:0][spcr_pkg::DEN_W:0] diff_next;
        logic [2:0]                    ge_next;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_next[i]    = {rem_reg[g][i], bits_reg[g][i][N-1]};
                ge_next[i]   = (t_next[i] >= {1'b0, den_reg[g]});
                diff_next[i] = t_next[i] - {1'b0, den_reg[g]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[g+1]  <= den_reg[g];
            side_reg[g+1] <= side_reg[g];
            big_reg[g+1]  <= big_reg[g];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[g+1][i]  <= ge_next[i] ? diff_next[i][spcr_pkg::DEN_W-1:0]
                                               : t_next[i][spcr_pkg::DEN_W-1:0];
                bits_reg[g+1][i] <= {bits_reg[g][i][N-2:0], 1'b0};
                quo_reg[g+1][i]  <= {quo_reg[g][i][N-2:0], ge_next[i]};
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo   = quo_reg[N];
    assign out_rem   = rem_reg[N];
    assign out_big   = big_reg[N];
    assign out_den   = den_reg[N];
    assign out_side  = side_reg[N];

endmodule
